// File: rtl/core/thwf_pkg.sv
// Shared types, codes and CRC helper for the three-wire HCI framer.
package thwf_pkg;

   // Request opcodes
   localparam logic [1:0] OpRxByte   = 2'd0;
   localparam logic [1:0] OpTxStart  = 2'd1;
   localparam logic [1:0] OpTxBody   = 2'd2;

   // Result kinds
   localparam logic KindRx = 1'b0;
   localparam logic KindTx = 1'b1;

   // Receive status codes
   localparam logic [1:0] StOk      = 2'd0;
   localparam logic [1:0] StBadLen  = 2'd1;
   localparam logic [1:0] StHdrSum  = 2'd2;
   localparam logic [1:0] StCrcFail = 2'd3;

   // Acknowledge outcomes
   localparam logic [1:0] AckNone  = 2'd0;
   localparam logic [1:0] AckOk    = 2'd1;
   localparam logic [1:0] AckRetx  = 2'd2;

   // Header fields and constants
   localparam int          FlagIntegrityBit = 6;
   localparam logic [1:0]  HdrFlags         = 2'b11;   // reliable and integrity
   localparam logic [3:0]  LinkOpcode       = 4'd14;
   localparam logic [15:0] CrcInit          = 16'hFFFF;
   localparam logic [2:0]  SeqReset         = 3'd1;
   localparam logic [12:0] CountMax         = 13'd8191;
   localparam int          HeaderBytes      = 4;

   // Up to six line bytes per request (header plus CRC on an empty frame)
   localparam int MaxResults = 6;
   localparam int CountWidth = 3;

   typedef struct packed {
      logic                       kind;
      logic [CountWidth-1:0]      count;
      logic [MaxResults-1:0][7:0] bytes;
      logic                       in_body;
      logic                       packet_done;
      logic [1:0]                 status;
      logic [1:0]                 ack_result;
      logic [11:0]                payload_len;
      logic                       frame_close;
   } bundle_type;

   // One byte step of CRC-16/CCITT, byte-wise form
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = {crc[7:0], crc[15:8]};
      c = c ^ {8'h00, b};
      c = c ^ {12'h000, c[7:4]};
      c = c ^ {c[3:0], 12'h000};
      c = c ^ {3'b000, c[7:0], 5'b00000};
      return c;
   endfunction

endpackage

// File: rtl/core/thwf_if.sv
// Request and result channel interfaces of the three-wire HCI framer.
interface thwf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [7:0]  data_byte;
   logic        last;
   logic [11:0] body_bytes;

   modport source (output valid, output opcode, output data_byte, output last,
                   output body_bytes, input ready);
   modport sink   (input valid, input opcode, input data_byte, input last,
                   input body_bytes, output ready);
endinterface

interface thwf_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  byte_value;
   logic        in_body;
   logic        packet_done;
   logic [1:0]  status;
   logic [1:0]  ack_result;
   logic [11:0] payload_len;
   logic        frame_end;
   logic        run_last;

   modport source (output valid, output kind, output byte_value, output in_body,
                   output packet_done, output status, output ack_result,
                   output payload_len, output frame_end, output run_last, input ready);
   modport sink   (input valid, input kind, input byte_value, input in_body,
                   input packet_done, input status, input ack_result,
                   input payload_len, input frame_end, input run_last, output ready);
endinterface

// File: rtl/core/thwf_engine.sv
// Framing state and per-request result computation for the three-wire HCI framer.
module thwf_engine #(
   parameter int MAX_BODY_LEN = 4093
) (
   input  logic                clock,
   input  logic                reset,
   thwf_req_if.sink            req_bus,
   input  logic                free,
   output logic                load,
   output thwf_pkg::bundle_type bundle
);

   localparam logic [12:0] MaxLen = 13'(MAX_BODY_LEN);

   logic        accept;

   logic [2:0]  seq_ff, seq_in;
   logic [2:0]  ack_ff, ack_in;
   logic [12:0] rx_count_ff, rx_count_in;
   logic [7:0]  rx_sum_ff, rx_sum_in;
   logic [7:0]  rx_first_ff, rx_first_in;
   logic [15:0] rx_crc_ff, rx_crc_in;
   logic [7:0]  rx_d0_ff, rx_d0_in;
   logic [7:0]  rx_d1_ff, rx_d1_in;
   logic [15:0] tx_crc_ff, tx_crc_in;
   logic        tx_active_ff, tx_active_in;

   // receive working values
   logic [7:0]  sum_new, first_new;
   logic [15:0] crc_new, body_crc;
   logic [12:0] cnt_new, plen;
   logic        integ;
   logic [1:0]  st;
   logic [2:0]  peer_ack;

   // transmit working values
   logic [7:0]  h0, h1, h2, h3;
   logic [11:0] len_field;
   logic [15:0] c1, c2, c3, c4;

   assign accept         = req_bus.valid && free;
   assign req_bus.ready  = free;

   // Low and high bytes of the body CRC after the final body byte
   function automatic logic [7:0] c1_body_lo(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = thwf_pkg::crc_byte(crc, b);
      return c[7:0];
   endfunction

   function automatic logic [7:0] c1_body_hi(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = thwf_pkg::crc_byte(crc, b);
      return c[15:8];
   endfunction

   // Receive path: running sums, CRC lagging by two bytes, and end-of-packet checks
   always_comb begin
      sum_new   = (rx_count_ff < 13'd4) ? rx_sum_ff + req_bus.data_byte : rx_sum_ff;
      first_new = (rx_count_ff == 13'd0) ? req_bus.data_byte : rx_first_ff;
      crc_new   = (rx_count_ff >= 13'd2) ? thwf_pkg::crc_byte(rx_crc_ff, rx_d0_ff) : rx_crc_ff;
      cnt_new   = (rx_count_ff < thwf_pkg::CountMax) ? rx_count_ff + 13'd1 : rx_count_ff;
      integ     = first_new[thwf_pkg::FlagIntegrityBit];
      plen      = cnt_new - 13'd4 - (integ ? 13'd2 : 13'd0);
      body_crc  = {req_bus.data_byte, rx_d1_ff};
      peer_ack  = first_new[5:3];
      if (cnt_new < 13'd4 || (integ && cnt_new < 13'd6)) begin
         st = thwf_pkg::StBadLen;
      end else if (plen > MaxLen) begin
         st = thwf_pkg::StBadLen;
      end else if (sum_new != 8'h00) begin
         st = thwf_pkg::StHdrSum;
      end else if (integ && body_crc != crc_new) begin
         st = thwf_pkg::StCrcFail;
      end else begin
         st = thwf_pkg::StOk;
      end
   end

   // Transmit header and its CRC chain
   always_comb begin
      len_field = req_bus.body_bytes + 12'd2;
      h0 = {thwf_pkg::HdrFlags, ack_ff, seq_ff};
      h1 = {len_field[3:0], thwf_pkg::LinkOpcode};
      h2 = len_field[11:4];
      h3 = 8'h00 - (h0 + h1 + h2);
      c1 = thwf_pkg::crc_byte(thwf_pkg::CrcInit, h0);
      c2 = thwf_pkg::crc_byte(c1, h1);
      c3 = thwf_pkg::crc_byte(c2, h2);
      c4 = thwf_pkg::crc_byte(c3, h3);
   end

   // Next state and result bundle
   always_comb begin
      seq_in       = seq_ff;
      ack_in       = ack_ff;
      rx_count_in  = rx_count_ff;
      rx_sum_in    = rx_sum_ff;
      rx_first_in  = rx_first_ff;
      rx_crc_in    = rx_crc_ff;
      rx_d0_in     = rx_d0_ff;
      rx_d1_in     = rx_d1_ff;
      tx_crc_in    = tx_crc_ff;
      tx_active_in = tx_active_ff;

      bundle             = '0;
      bundle.kind        = thwf_pkg::KindTx;

      case (req_bus.opcode)
         thwf_pkg::OpRxByte: begin
            bundle.kind     = thwf_pkg::KindRx;
            bundle.count    = thwf_pkg::CountWidth'(1);
            bundle.bytes[0] = req_bus.data_byte;
            bundle.in_body  = (rx_count_ff >= 13'(thwf_pkg::HeaderBytes));
            if (req_bus.last) begin
               bundle.packet_done = 1'b1;
               bundle.status      = st;
               if (st == thwf_pkg::StOk) begin
                  bundle.payload_len = plen[11:0];
                  ack_in             = first_new[2:0] + 3'd1;
                  if (peer_ack == seq_ff) begin
                     bundle.ack_result = thwf_pkg::AckRetx;
                  end else begin
                     seq_in            = peer_ack;
                     bundle.ack_result = thwf_pkg::AckOk;
                  end
               end
               rx_count_in = '0;
               rx_sum_in   = '0;
               rx_first_in = '0;
               rx_crc_in   = thwf_pkg::CrcInit;
               rx_d0_in    = '0;
               rx_d1_in    = '0;
            end else begin
               rx_count_in = cnt_new;
               rx_sum_in   = sum_new;
               rx_first_in = first_new;
               rx_crc_in   = crc_new;
               rx_d0_in    = rx_d1_ff;
               rx_d1_in    = req_bus.data_byte;
            end
         end
         thwf_pkg::OpTxStart: begin
            bundle.bytes[0] = h0;
            bundle.bytes[1] = h1;
            bundle.bytes[2] = h2;
            bundle.bytes[3] = h3;
            if (req_bus.body_bytes == 12'd0) begin
               bundle.count       = thwf_pkg::CountWidth'(6);
               bundle.bytes[4]    = c4[7:0];
               bundle.bytes[5]    = c4[15:8];
               bundle.frame_close = 1'b1;
               tx_active_in       = 1'b0;
               tx_crc_in          = thwf_pkg::CrcInit;
            end else begin
               bundle.count = thwf_pkg::CountWidth'(4);
               tx_active_in = 1'b1;
               tx_crc_in    = c4;
            end
         end
         thwf_pkg::OpTxBody: begin
            if (tx_active_ff) begin
               bundle.bytes[0] = req_bus.data_byte;
               if (req_bus.last) begin
                  bundle.count       = thwf_pkg::CountWidth'(3);
                  bundle.bytes[1]    = c1_body_lo(tx_crc_ff, req_bus.data_byte);
                  bundle.bytes[2]    = c1_body_hi(tx_crc_ff, req_bus.data_byte);
                  bundle.frame_close = 1'b1;
                  tx_active_in       = 1'b0;
                  tx_crc_in          = thwf_pkg::CrcInit;
               end else begin
                  bundle.count = thwf_pkg::CountWidth'(1);
                  tx_crc_in    = thwf_pkg::crc_byte(tx_crc_ff, req_bus.data_byte);
               end
            end
         end
         default: begin
            bundle.count = '0;
         end
      endcase
   end

   assign load = accept && (bundle.count != '0);

   // State registers, updated on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= thwf_pkg::SeqReset;
         ack_ff       <= '0;
         rx_count_ff  <= '0;
         rx_sum_ff    <= '0;
         rx_first_ff  <= '0;
         rx_crc_ff    <= thwf_pkg::CrcInit;
         rx_d0_ff     <= '0;
         rx_d1_ff     <= '0;
         tx_crc_ff    <= thwf_pkg::CrcInit;
         tx_active_ff <= 1'b0;
      end else if (accept) begin
         seq_ff       <= seq_in;
         ack_ff       <= ack_in;
         rx_count_ff  <= rx_count_in;
         rx_sum_ff    <= rx_sum_in;
         rx_first_ff  <= rx_first_in;
         rx_crc_ff    <= rx_crc_in;
         rx_d0_ff     <= rx_d0_in;
         rx_d1_ff     <= rx_d1_in;
         tx_crc_ff    <= tx_crc_in;
         tx_active_ff <= tx_active_in;
      end
   end

endmodule

// File: rtl/core/thwf_emit.sv
// Result register and sequencer that plays out the bytes of one request.
module thwf_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  thwf_pkg::bundle_type bundle,
   output logic                 free,
   thwf_rsp_if.source           rsp_bus
);

   thwf_pkg::bundle_type            bundle_ff;
   logic                            busy_ff;
   logic [thwf_pkg::CountWidth-1:0] idx_ff;
   logic                            final_one;
   logic                            take;

   assign final_one = (idx_ff == bundle_ff.count - thwf_pkg::CountWidth'(1));
   assign take      = busy_ff && rsp_bus.ready;
   assign free      = !busy_ff || (rsp_bus.ready && final_one);

   // Result payload from the held bundle
   assign rsp_bus.valid       = busy_ff;
   assign rsp_bus.kind        = bundle_ff.kind;
   assign rsp_bus.byte_value  = bundle_ff.bytes[idx_ff];
   assign rsp_bus.in_body     = bundle_ff.in_body;
   assign rsp_bus.packet_done = bundle_ff.packet_done;
   assign rsp_bus.status      = bundle_ff.status;
   assign rsp_bus.ack_result  = bundle_ff.ack_result;
   assign rsp_bus.payload_len = bundle_ff.payload_len;
   assign rsp_bus.frame_end   = bundle_ff.frame_close && final_one;
   assign rsp_bus.run_last    = final_one;

   // Bundle holding register, no reset needed
   always_ff @(posedge clock) begin
      if (load) begin
         bundle_ff <= bundle;
      end
   end

   // Sequencer control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (take) begin
         if (final_one) begin
            busy_ff <= 1'b0;
            idx_ff  <= '0;
         end else begin
            idx_ff  <= idx_ff + thwf_pkg::CountWidth'(1);
         end
      end
   end

endmodule

// File: rtl/core/three_wire_hci_framer.sv
// Top level of the three-wire HCI packet framer and deframer.
// Usage:
//   req_bus carries one request per valid/ready handshake: a received line byte,
//   a transmit frame start with its body length, or a transmit body byte.
//   rsp_bus returns the results in order, one per handshake; run_last marks the
//   final result of a request, frame_end the final byte of a transmit frame and
//   packet_done the end of a received packet with its status and ack outcome.
// Result timing: the first result of a request is on rsp_bus the cycle after it is taken.
// Throughput: while rsp_bus.ready is high, a request giving one result (receive
//   byte, body byte) is taken every cycle. A request giving N results (4 for a
//   start, 6 for an empty frame, 3 for a final body byte) holds req_bus.ready low
//   until its final result leaves the single result register. Requests giving no
//   result (body byte with no open frame, unused opcode) are taken and dropped.
// Reset: synchronous, active high; sequence number returns to 1, acknowledge
//   number to 0, receive state and CRCs to their initial values, no frame open.
// Stall: while rsp_bus.ready is low the held result stays put and no new request
//   is taken; ready returns in the same cycle the final pending result leaves.
module three_wire_hci_framer #(
   parameter int MAX_BODY_LEN = 4093
) (
   input  logic        clock,
   input  logic        reset,
   thwf_req_if.sink    req_bus,
   thwf_rsp_if.source  rsp_bus
);

   logic                 free;
   logic                 load;
   thwf_pkg::bundle_type bundle;

   // Framing state and result computation
   thwf_engine #(
      .MAX_BODY_LEN (MAX_BODY_LEN)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .free    (free),
      .load    (load),
      .bundle  (bundle)
   );

   // Result register and byte sequencer
   thwf_emit u_emit (
      .clock   (clock),
      .reset   (reset),
      .load    (load),
      .bundle  (bundle),
      .free    (free),
      .rsp_bus (rsp_bus)
   );

endmodule

// File: dv/three_wire_hci_framer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the three-wire HCI framer: deframing checks, framing, stalls.
module three_wire_hci_framer_tb;

   localparam int         MAX_BODY_LEN   = 4093;
   localparam logic [1:0] OpUnused       = 2'd3;
   localparam int         RspHoldCycles  = 300;
   localparam int         StallLimit     = 2000;
   localparam int         RandomRequests = 50;

   // One line byte as it should appear on the result channel
   typedef struct packed {
      logic        kind;
      logic [7:0]  byte_value;
      logic        in_body;
      logic        packet_done;
      logic [1:0]  status;
      logic [1:0]  ack_result;
      logic [11:0] payload_len;
      logic        frame_end;
      logic        run_last;
   } line_result_type;

   // Ways a generated receive packet is spoilt
   typedef enum logic [1:0] {FaultNone, FaultHdrSum, FaultCrc, FaultShort} rx_fault_type;

   logic clock;
   logic reset;

   thwf_req_if req_bus ();
   thwf_rsp_if rsp_bus ();

   three_wire_hci_framer #(.MAX_BODY_LEN(MAX_BODY_LEN)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Link state as the framer should hold it
   logic [2:0]  seq_no;
   logic [2:0]  ack_no;
   logic [12:0] rx_cnt;
   logic [7:0]  rx_hsum;
   logic [7:0]  rx_first;
   logic [15:0] rx_crc;
   logic [7:0]  rx_dly0;
   logic [7:0]  rx_dly1;
   logic [15:0] tx_crc;
   logic        tx_open;

   line_result_type line_expect_q[$];
   int mismatch_count      = 0;
   int productive_requests = 0;
   int quiet_cycles        = 0;
   bit no_idle             = 1'b0;
   bit hold_rsp            = 1'b0;

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // CRC-16/CCITT, polynomial 0x1021, shifted one bit at a time
   function automatic logic [15:0] crc_ccitt_next(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++)
         c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      return c;
   endfunction

   function automatic void clear_rx_state();
      rx_cnt  = '0;
      rx_hsum = '0;
      rx_first = '0;
      rx_crc  = thwf_pkg::CrcInit;
      rx_dly0 = '0;
      rx_dly1 = '0;
   endfunction

   function automatic line_result_type tx_line(input logic [7:0] v, input logic fend);
      line_result_type r;
      r = '0;
      r.kind       = thwf_pkg::KindTx;
      r.byte_value = v;
      r.frame_end  = fend;
      return r;
   endfunction

   // Work out the line bytes one accepted request produces and queue them
   function automatic void predict_request(input logic [1:0] op, input logic [7:0] b,
                                           input logic lst, input logic [11:0] blen);
      line_result_type res [thwf_pkg::MaxResults];
      int           n;
      int           idx;
      int           len;
      int           plen;
      logic [1:0]   st;
      logic [1:0]   ackr;
      logic         integ;
      logic         close_frame;
      logic [7:0]   hdr [4];
      logic [15:0]  word;
      n = 0;
      close_frame = 1'b0;
      for (int i = 0; i < thwf_pkg::MaxResults; i++) res[i] = '0;
      case (op)
         thwf_pkg::OpRxByte: begin
            idx = rx_cnt;
            if (idx < thwf_pkg::HeaderBytes) rx_hsum = rx_hsum + b;
            if (idx == 0) rx_first = b;
            // CRC runs two bytes behind so the trailer is left out
            if (idx >= 2) rx_crc = crc_ccitt_next(rx_crc, rx_dly0);
            rx_dly0 = rx_dly1;
            rx_dly1 = b;
            if (rx_cnt != thwf_pkg::CountMax) rx_cnt = rx_cnt + 13'd1;
            res[0].kind       = thwf_pkg::KindRx;
            res[0].byte_value = b;
            res[0].in_body    = (idx >= thwf_pkg::HeaderBytes);
            n = 1;
            if (lst) begin
               len   = rx_cnt;
               integ = rx_first[thwf_pkg::FlagIntegrityBit];
               st    = thwf_pkg::StOk;
               ackr  = thwf_pkg::AckNone;
               plen  = 0;
               if (len < thwf_pkg::HeaderBytes ||
                   (integ && len < thwf_pkg::HeaderBytes + 2)) begin
                  st = thwf_pkg::StBadLen;
               end else begin
                  plen = len - thwf_pkg::HeaderBytes - (integ ? 2 : 0);
                  if (plen > MAX_BODY_LEN) st = thwf_pkg::StBadLen;
                  else if (rx_hsum != 8'd0) st = thwf_pkg::StHdrSum;
                  else if (integ && {rx_dly1, rx_dly0} != rx_crc) st = thwf_pkg::StCrcFail;
               end
               if (st == thwf_pkg::StOk) begin
                  ack_no = rx_first[2:0] + 3'd1;
                  if (rx_first[5:3] == seq_no) begin
                     ackr = thwf_pkg::AckRetx;
                  end else begin
                     seq_no = rx_first[5:3];
                     ackr   = thwf_pkg::AckOk;
                  end
               end else begin
                  plen = 0;
               end
               res[0].packet_done = 1'b1;
               res[0].status      = st;
               res[0].ack_result  = ackr;
               res[0].payload_len = plen[11:0];
               clear_rx_state();
            end
         end
         thwf_pkg::OpTxStart: begin
            hdr[0] = {thwf_pkg::HdrFlags, ack_no, seq_no};
            word   = {4'd0, blen} + 16'd2;
            word   = (word << 4) + {12'd0, thwf_pkg::LinkOpcode};
            hdr[1] = word[7:0];
            hdr[2] = word[15:8];
            hdr[3] = 8'd0 - (hdr[0] + hdr[1] + hdr[2]);
            tx_crc = thwf_pkg::CrcInit;
            for (int i = 0; i < thwf_pkg::HeaderBytes; i++) begin
               tx_crc = crc_ccitt_next(tx_crc, hdr[i]);
               res[n] = tx_line(hdr[i], 1'b0);
               n = n + 1;
            end
            tx_open = 1'b1;
            close_frame = (blen == 12'd0);
         end
         thwf_pkg::OpTxBody: begin
            // body bytes with no open frame are dropped
            if (tx_open) begin
               tx_crc = crc_ccitt_next(tx_crc, b);
               res[0] = tx_line(b, 1'b0);
               n = 1;
               close_frame = lst;
            end
         end
         default: ;
      endcase
      // trailer goes out low byte first
      if (close_frame) begin
         res[n]     = tx_line(tx_crc[7:0], 1'b0);
         res[n + 1] = tx_line(tx_crc[15:8], 1'b1);
         n = n + 2;
         tx_open = 1'b0;
         tx_crc  = thwf_pkg::CrcInit;
      end
      if (n > 0) begin
         res[n - 1].run_last = 1'b1;
         productive_requests++;
      end
      for (int i = 0; i < n; i++) line_expect_q.push_back(res[i]);
   endfunction

   // Mostly back to back, some short gaps, a few long ones
   function automatic int idle_length();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Offer one request and wait for the handshake
   task automatic send_request(input logic [1:0] op, input logic [7:0] b, input logic lst,
                               input logic [11:0] blen);
      int gap;
      gap = idle_length();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= op;
      req_bus.data_byte  <= b;
      req_bus.last       <= lst;
      req_bus.body_bytes <= blen;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_request(op, b, lst, blen);
   endtask

   // Stop offering until every queued line byte has come back
   task automatic pause_until_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (line_expect_q.size() != 0);
   endtask

   // Build a receive packet from the peer and stream it in; for a short
   // packet size_arg is the number of bytes kept, otherwise the body length
   task automatic send_rx_packet(input logic integ, input logic [2:0] pseq,
                                 input logic [2:0] pack, input int size_arg,
                                 input rx_fault_type fault);
      logic [7:0]  pkt[$];
      logic [15:0] crc;
      int          body_len;
      body_len = (fault == FaultShort) ? 0 : size_arg;
      pkt.push_back({1'b1, integ, pack, pseq});
      pkt.push_back(8'($urandom));
      pkt.push_back(8'($urandom));
      pkt.push_back(8'd0 - (pkt[0] + pkt[1] + pkt[2]));
      if (fault == FaultHdrSum) pkt[3] = pkt[3] + 8'($urandom_range(1, 255));
      repeat (body_len) pkt.push_back(8'($urandom));
      if (integ) begin
         crc = thwf_pkg::CrcInit;
         foreach (pkt[i]) crc = crc_ccitt_next(crc, pkt[i]);
         if (fault == FaultCrc) crc = crc ^ 16'($urandom_range(1, 65535));
         pkt.push_back(crc[7:0]);
         pkt.push_back(crc[15:8]);
      end
      if (fault == FaultShort)
         while (pkt.size() > size_arg) void'(pkt.pop_back());
      for (int i = 0; i < pkt.size(); i++)
         send_request(thwf_pkg::OpRxByte, pkt[i], i == pkt.size() - 1, 12'($urandom));
   endtask

   task automatic send_tx_frame(input logic [11:0] blen, input int nbody);
      send_request(thwf_pkg::OpTxStart, 8'($urandom), 1'($urandom), blen);
      for (int i = 0; i < nbody; i++)
         send_request(thwf_pkg::OpTxBody, 8'($urandom), i == nbody - 1, 12'($urandom));
   endtask

   // Receive side: good, retransmit and each failing check
   task automatic test_rx_directed();
      send_rx_packet(1'b1, 3'd5, seq_no, 0, FaultNone);
      send_rx_packet(1'b0, 3'd7, seq_no + 3'd1, 0, FaultNone);
      send_rx_packet(1'b0, 3'd0, 3'd2, 1, FaultShort);
      send_rx_packet(1'b1, 3'd1, 3'd3, 5, FaultShort);
      send_rx_packet(1'b0, 3'd2, 3'd4, 0, FaultHdrSum);
      send_rx_packet(1'b1, 3'd3, 3'd6, 0, FaultCrc);
   endtask

   // Transmit side: empty frame, largest length, restart, stray body, unused opcode
   task automatic test_tx_directed();
      send_request(thwf_pkg::OpTxStart, 8'h00, 1'b0, 12'd0);
      send_request(thwf_pkg::OpTxStart, 8'hFF, 1'b1, 12'(MAX_BODY_LEN));
      send_request(thwf_pkg::OpTxBody, 8'hFF, 1'b0, 12'hFFF);
      send_request(thwf_pkg::OpTxStart, 8'h00, 1'b0, 12'd5);
      send_request(thwf_pkg::OpTxBody, 8'h00, 1'b1, 12'd0);
      send_request(thwf_pkg::OpTxBody, 8'hA5, 1'b1, 12'd0);
      send_request(OpUnused, 8'h5A, 1'b1, 12'hAAA);
   endtask

   // Receiver holds off while requests keep coming, then the sender waits for all
   task automatic test_backpressure();
      no_idle  = 1'b1;
      hold_rsp = 1'b1;
      send_rx_packet(1'b1, 3'($urandom), 3'($urandom), 8, FaultNone);
      send_tx_frame(12'd3, 3);
      send_tx_frame(12'd0, 0);
      pause_until_drained();
      no_idle = 1'b0;
   endtask

   // Mostly well-formed packets and frames with random content, some faults and noise
   task automatic test_random();
      int         target;
      int         r;
      int         blen;
      logic       integ;
      logic [2:0] pseq;
      logic [2:0] pack;
      target = productive_requests + RandomRequests;
      while (productive_requests < target) begin
         no_idle = ($urandom_range(0, 7) == 0);
         r     = $urandom_range(0, 99);
         integ = 1'($urandom);
         pseq  = 3'($urandom);
         pack  = ($urandom_range(0, 2) == 0) ? seq_no : 3'($urandom);
         if (r < 40) begin
            send_rx_packet(integ, pseq, pack, $urandom_range(0, 6), FaultNone);
         end else if (r < 55) begin
            case ($urandom_range(0, 2))
               0: send_rx_packet(integ, pseq, pack, $urandom_range(0, 6), FaultHdrSum);
               1: send_rx_packet(1'b1, pseq, pack, $urandom_range(0, 6), FaultCrc);
               default: send_rx_packet(integ, pseq, pack,
                                       integ ? $urandom_range(1, 5) : $urandom_range(1, 3),
                                       FaultShort);
            endcase
         end else if (r < 85) begin
            blen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_BODY_LEN)
                                                : $urandom_range(0, 5);
            send_tx_frame(12'(blen), $urandom_range(0, 4));
         end else begin
            send_request(2'($urandom), 8'($urandom), 1'($urandom),
                         12'($urandom_range(0, MAX_BODY_LEN)));
         end
      end
      no_idle = 1'b0;
   endtask

   // Result channel ready: random stalls, plus one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
            repeat (RspHoldCycles) @(posedge clock);
            hold_rsp = 1'b0;
            rsp_bus.ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = idle_length();
         end
      end
   end

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Compare each line byte that leaves with the oldest one queued
   always @(posedge clock) begin
      line_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (line_expect_q.size() == 0) begin
            $error("result 0x%0h with nothing pending", rsp_bus.byte_value);
            mismatch_count++;
         end else begin
            want = line_expect_q.pop_front();
            check_field("kind", want.kind, rsp_bus.kind);
            check_field("byte_value", want.byte_value, rsp_bus.byte_value);
            check_field("in_body", want.in_body, rsp_bus.in_body);
            check_field("packet_done", want.packet_done, rsp_bus.packet_done);
            check_field("status", want.status, rsp_bus.status);
            check_field("ack_result", want.ack_result, rsp_bus.ack_result);
            check_field("payload_len", want.payload_len, rsp_bus.payload_len);
            check_field("frame_end", want.frame_end, rsp_bus.frame_end);
            check_field("run_last", want.run_last, rsp_bus.run_last);
         end
      end
   end

   // Watchdog: too long with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.opcode     <= thwf_pkg::OpRxByte;
      req_bus.data_byte  <= 8'd0;
      req_bus.last       <= 1'b0;
      req_bus.body_bytes <= 12'd0;
      seq_no  = thwf_pkg::SeqReset;
      ack_no  = 3'd0;
      tx_crc  = thwf_pkg::CrcInit;
      tx_open = 1'b0;
      clear_rx_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_rx_directed();
      test_tx_directed();
      test_backpressure();
      test_random();

      // let everything drain, then keep watching for anything stray
      req_bus.valid <= 1'b0;
      while (line_expect_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && line_expect_q.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
